>>> rtl/spc_pkg.sv
// Shared constants and arithmetic helpers for the sprite pixel alpha compositor.
// Used by the top level, the checker and the testbench; depends on nothing else.
package spc_pkg;

	// Default palette depth.
	localparam int PALETTE_ENTRIES_DEF = 256;

	// Channel and field widths.
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 32;
	localparam int ADDR_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int MODE_W  = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPACITY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSP_IDX  = 2'd2;

	// Source pixel formats. Code 3 is decoded like the indexed format.
	localparam logic [MODE_W-1:0] MODE_RGBA    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GRAY    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INDEXED = 2'd2;

	// Item kinds carried in tuser.
	localparam logic CMD_PAL_WRITE = 1'b0;
	localparam logic CMD_BLEND     = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [MODE_W-1:0] MODE_RESET    = MODE_RGBA;
	localparam logic [CHAN_W-1:0] OPACITY_RESET = 8'hFF;
	localparam logic [CHAN_W-1:0] TRANSP_RESET  = 8'h00;

	// Rounding term of the 8-bit multiply.
	localparam logic [CHAN_W-1:0] MUL_ROUND = 8'h80;

	// Channel divider: quotient bits, bits resolved per stage, stage count.
	localparam int QUOT_W       = CHAN_W;
	localparam int DIV_BITS     = 2;
	localparam int DIV_STAGES   = QUOT_W / DIV_BITS;
	localparam int DIV_WORD_W   = 2 * CHAN_W;

	typedef logic [2:0][CHAN_W-1:0] rgb_t;
	typedef logic [2:0][DIV_WORD_W-1:0] div_word_t;

	// Rounded product x*y/255 on 8-bit values.
	function automatic logic [CHAN_W-1:0] mul8(input logic [CHAN_W-1:0] x,
			input logic [CHAN_W-1:0] y);
		logic [16:0] t;
		logic [16:0] u;
		t = 17'(x) * 17'(y) + 17'(MUL_ROUND);
		u = (t >> 8) + t;
		return u[15:8];
	endfunction

	// Restoring division steps. The upper half of the word holds the partial
	// remainder (always below the divisor), the lower half holds numerator bits
	// still to be consumed on the left and quotient bits shifted in on the right.
	function automatic logic [DIV_WORD_W-1:0] div_step(input logic [DIV_WORD_W-1:0] w,
			input logic [CHAN_W-1:0] divisor);
		logic [DIV_WORD_W-1:0] cur;
		logic [CHAN_W:0]       r9;
		logic [CHAN_W-1:0]     low;
		cur = w;
		for (int i = 0; i < DIV_BITS; i++) begin
			r9  = {cur[DIV_WORD_W-1:CHAN_W], cur[CHAN_W-1]};
			low = {cur[CHAN_W-2:0], 1'b0};
			if (r9 >= {1'b0, divisor}) begin
				r9     = r9 - {1'b0, divisor};
				low[0] = 1'b1;
			end
			cur = {r9[CHAN_W-1:0], low};
		end
		return cur;
	endfunction

endpackage

>>> rtl/sprite_pixel_alpha_compositor.sv
// Top level of the sprite pixel alpha compositor: eight-stage blend pipeline.
// Depends on spc_pkg and instantiates spc_ram for the palette.
//
// Usage. Items arrive on the s_ channel; tuser selects the kind. A palette
// write stores entry_color at entry_address and yields no result. A blend
// decodes src_raw by the pixel mode, composites it over dst_color with
// straight alpha and yields one out_color item on the m_ channel, in order.
//
// Pipeline and throughput. One item is taken per clock unless stalled. A
// blend result passes through the palette read, decode and opacity scaling,
// combined alpha and channel products, four division stages of two quotient
// bits each, then the output register. The palette memory has one write and
// one read port, so any mix of writes and blends runs at one item per cycle
// unless stalled.
//
// Stalls. Every stage has its own valid bit and moves whenever the stage
// after it is empty or moving, so bubbles close up while the receiver holds
// m_tready low; s_tready falls only when all eight stages are full.
//
// Reset. arst_n clears all valid bits and sets the registers to rgba mode,
// full opacity and transparent index zero. The palette is not cleared: an
// entry must be written before a blend in indexed mode reads it. The user
// must write configuration via cfg_we with no item in flight (unenforced).
module sprite_pixel_alpha_compositor #(
	parameter int PALETTE_ENTRIES = spc_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input items.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// From bit 0: entry_address[7:0], entry_color[31:0], src_raw[31:0],
	// dst_color[31:0].
	input  logic [103:0]                    s_tdata,
	// cmd: 0 palette write, 1 blend.
	input  logic                            s_tuser,
	// Result items.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// From bit 0: out_color[31:0].
	output logic [spc_pkg::COLOR_W-1:0]     m_tdata,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
	localparam int CW     = spc_pkg::CHAN_W;
	localparam int NDIV   = spc_pkg::DIV_STAGES;

	// Input field unpacking.
	logic [spc_pkg::ADDR_W-1:0]  entry_address;
	logic [spc_pkg::COLOR_W-1:0] entry_color;
	logic [spc_pkg::COLOR_W-1:0] src_raw;
	logic [spc_pkg::COLOR_W-1:0] dst_color;

	assign entry_address = s_tdata[7:0];
	assign entry_color   = s_tdata[39:8];
	assign src_raw       = s_tdata[71:40];
	assign dst_color     = s_tdata[103:72];

	// Configuration registers.
	logic [spc_pkg::MODE_W-1:0] mode_q;
	logic [CW-1:0]              opacity_q;
	logic [CW-1:0]              tidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= spc_pkg::MODE_RESET;
			opacity_q <= spc_pkg::OPACITY_RESET;
			tidx_q    <= spc_pkg::TRANSP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spc_pkg::CFG_PIXEL_MODE: mode_q    <= cfg_wdata[spc_pkg::MODE_W-1:0];
				spc_pkg::CFG_OPACITY:    opacity_q <= cfg_wdata;
				spc_pkg::CFG_TRANSP_IDX: tidx_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage enables. A stage loads when it is empty or its content moves on.
	logic            en_s1, en_s2, en_s3, en_s8;
	logic            vld_s1, vld_s2, vld_s3, vld_s8;
	logic [NDIV-1:0] div_vld_s;
	logic [NDIV-1:0] div_en;

	assign en_s8 = !vld_s8 || m_tready;
	assign en_s3 = !vld_s3 || div_en[0];
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign s_tready = en_s1;

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	// Palette memory. Writes happen at acceptance; the read for a blend item
	// is issued at acceptance too and held while stage one is stalled.
	logic                        pal_we;
	logic [spc_pkg::COLOR_W-1:0] pal_rdata;

	assign pal_we = in_acc && (s_tuser == spc_pkg::CMD_PAL_WRITE)
		&& ({1'b0, entry_address} < 9'(PALETTE_ENTRIES));

	spc_ram #(
		.WIDTH (spc_pkg::COLOR_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (entry_address[PAL_AW-1:0]),
		.wdata (entry_color),
		.re    (en_s1),
		.raddr (src_raw[PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	// Stage 1: palette read in flight, index checks.
	logic [spc_pkg::COLOR_W-1:0] src_raw_s1;
	logic [spc_pkg::COLOR_W-1:0] dst_s1;
	logic                        clear_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= s_tvalid && (s_tuser == spc_pkg::CMD_BLEND);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			src_raw_s1 <= src_raw;
			dst_s1     <= dst_color;
			// The transparent index and indexes past the palette give clear black.
			clear_s1   <= (src_raw[7:0] == tidx_q)
				|| ({1'b0, src_raw[7:0]} >= 9'(PALETTE_ENTRIES));
		end
	end

	// Stage 2: source decode and opacity scaling of source alpha.
	logic [spc_pkg::COLOR_W-1:0] src_dec;
	spc_pkg::rgb_t               src_s2;
	spc_pkg::rgb_t               dst_s2;
	logic [CW-1:0]               da_s2;
	logic [CW-1:0]               sa_s2;

	always_comb begin
		unique case (mode_q)
			spc_pkg::MODE_RGBA: src_dec = src_raw_s1;
			spc_pkg::MODE_GRAY: src_dec = {src_raw_s1[15:8], src_raw_s1[7:0],
				src_raw_s1[7:0], src_raw_s1[7:0]};
			// Indexed format, and the unused fourth code, which behaves alike.
			default:            src_dec = clear_s1 ? '0 : pal_rdata;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			src_s2 <= src_dec[23:0];
			dst_s2 <= dst_s1[23:0];
			da_s2  <= dst_s1[31:24];
			sa_s2  <= spc_pkg::mul8(src_dec[31:24], opacity_q);
		end
	end

	// Stage 3: combined alpha and the channel products |s - d| * sa.
	logic [CW-1:0]        ma;
	logic [CW-1:0]        alpha_s3;
	spc_pkg::div_word_t   prod_s3;
	logic [2:0]           neg_s3;
	spc_pkg::rgb_t        dst_s3;

	assign ma = spc_pkg::mul8(sa_s2, da_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			alpha_s3 <= sa_s2 + da_s2 - ma;
			dst_s3   <= dst_s2;
			for (int c = 0; c < 3; c++) begin
				neg_s3[c]  <= src_s2[c] < dst_s2[c];
				prod_s3[c] <= (src_s2[c] >= dst_s2[c])
					? 16'(src_s2[c] - dst_s2[c]) * 16'(sa_s2)
					: 16'(dst_s2[c] - src_s2[c]) * 16'(sa_s2);
			end
		end
	end

	// Stages 4 to 7: restoring division of each product by the combined
	// alpha. The combined alpha is never below the source alpha, so the
	// quotient fits in eight bits and the upper product byte starts as a
	// valid remainder.
	spc_pkg::div_word_t div_w_s     [NDIV];
	logic [CW-1:0]      div_alpha_s [NDIV];
	logic [2:0]         div_neg_s   [NDIV];
	spc_pkg::rgb_t      div_dst_s   [NDIV];

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic               vin;
		logic               en_next;
		spc_pkg::div_word_t w_in;
		logic [CW-1:0]      alpha_in;
		logic [2:0]         neg_in;
		spc_pkg::rgb_t      dst_in;

		if (k == 0) begin : g_first
			assign vin      = vld_s3;
			assign w_in     = prod_s3;
			assign alpha_in = alpha_s3;
			assign neg_in   = neg_s3;
			assign dst_in   = dst_s3;
		end else begin : g_next
			assign vin      = div_vld_s[k-1];
			assign w_in     = div_w_s[k-1];
			assign alpha_in = div_alpha_s[k-1];
			assign neg_in   = div_neg_s[k-1];
			assign dst_in   = div_dst_s[k-1];
		end

		if (k == NDIV - 1) begin : g_last
			assign en_next = en_s8;
		end else begin : g_mid
			assign en_next = div_en[k+1];
		end

		assign div_en[k] = !div_vld_s[k] || en_next;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (div_en[k]) begin
				div_vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (div_en[k]) begin
				div_alpha_s[k] <= alpha_in;
				div_neg_s[k]   <= neg_in;
				div_dst_s[k]   <= dst_in;
				for (int c = 0; c < 3; c++) begin
					div_w_s[k][c] <= spc_pkg::div_step(w_in[c], alpha_in);
				end
			end
		end
	end

	// Stage 8: signed correction of the destination and the output register.
	// A zero combined alpha gives an all-zero pixel.
	logic [spc_pkg::COLOR_W-1:0] out_s8;
	spc_pkg::rgb_t               chan_res;
	logic [CW-1:0]               alpha_fin;

	assign alpha_fin = div_alpha_s[NDIV-1];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			chan_res[c] = div_neg_s[NDIV-1][c]
				? div_dst_s[NDIV-1][c] - div_w_s[NDIV-1][c][CW-1:0]
				: div_dst_s[NDIV-1][c] + div_w_s[NDIV-1][c][CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en_s8) begin
			vld_s8 <= div_vld_s[NDIV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			out_s8 <= (alpha_fin == '0) ? '0 : {alpha_fin, chan_res};
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata  = out_s8;

endmodule

>>> rtl/spc_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Holds the palette of the compositor; uses no package.
module spc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/spc_checker.sv
// Port-level checks for the sprite pixel alpha compositor, bound to the top level.
// Depends on spc_pkg for field widths.
module spc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [103:0]                   s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [spc_pkg::COLOR_W-1:0]    m_tdata
);

	// An offered input item stays on the bus unchanged until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input item changed or dropped while stalled");

	// A result that is not taken stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// The pipeline comes out of reset empty.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result offered right after reset");

	// When the output register is free or draining, no stage can be blocked,
	// so the input side must be ready.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled although the output is moving");

	// A pixel with zero combined alpha carries no colour.
	a_clear_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:24] == 8'h00) |-> m_tdata == '0)
		else $error("zero-alpha result with nonzero colour");

endmodule

bind sprite_pixel_alpha_compositor spc_checker u_spc_checker (.*);

>>> tb/tb_sprite_pixel_alpha_compositor.sv
// Self-checking testbench for sprite_pixel_alpha_compositor.
// Needs spc_pkg and the compositor RTL; a shadow of the palette and registers
// predicts every composited pixel, which is checked as it leaves the block.
module tb_sprite_pixel_alpha_compositor;
	import spc_pkg::*;

	// Pixel mode code 3 is undefined and must decode like the indexed format.
	localparam logic [MODE_W-1:0] MODE_ALIAS_IDX = 2'd3;
	// Cycles let pass after the last result before touching the registers, so
	// that a palette write still in the pipe has landed.
	localparam int SETTLE_CYCLES = 12;
	// Number of random items per register setting and number of settings.
	localparam int ITEMS_PER_SETTING = 70;
	localparam int SETTING_COUNT     = 12;

	typedef struct {
		logic              cmd;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       color;
		logic [31:0]       src;
		logic [31:0]       dst;
	} pix_item_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	// From bit 0: entry_address[7:0], entry_color[31:0], src_raw[31:0], dst_color[31:0].
	logic [103:0]  s_tdata = '0;
	// cmd: 0 palette write, 1 blend.
	logic          s_tuser = CMD_PAL_WRITE;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	// From bit 0: out_color[31:0].
	logic [COLOR_W-1:0]    m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_PIXEL_MODE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	sprite_pixel_alpha_compositor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow of the block's registers and palette. The registers only change
	// while the block is idle, so the stimulus process updates them directly.
	logic [MODE_W-1:0] cur_mode       = MODE_RESET;
	logic [CHAN_W-1:0] cur_opacity    = OPACITY_RESET;
	logic [CHAN_W-1:0] cur_transp_idx = TRANSP_RESET;
	logic [31:0]       palette_shadow [PALETTE_ENTRIES_DEF];

	pix_item_t   pending_items[$];
	logic [31:0] expected_pixels[$];
	int          n_errors = 0;
	int          n_results = 0;
	// When set, neither side inserts random idle cycles.
	bit          calm = 1'b0;

	// Bookkeeping of the stimulus side: which palette entries have been written
	// by items already queued, so that a blend never reads an unwritten entry.
	bit          gen_written [PALETTE_ENTRIES_DEF];
	int          gen_written_list[$];

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Rounded product x*y/255 of two 8-bit values.
	function automatic int scale8(input int x, input int y);
		int t;
		t = x * y + int'(MUL_ROUND);
		return (((t >> 8) + t) >> 8) & 255;
	endfunction

	// One colour channel of the source-over rule; the quotient truncates toward
	// zero, which matters when the source is darker than the destination.
	function automatic logic [7:0] mix_channel(input int s, input int d, input int sa,
			input int a);
		int v;
		v = d + ((s - d) * sa) / a;
		return v[7:0];
	endfunction

	function automatic logic [31:0] composite_pixel(input logic [31:0] raw,
			input logic [31:0] dst);
		logic [31:0] src;
		logic [31:0] res;
		int          sa;
		int          da;
		int          a;
		case (cur_mode)
			MODE_RGBA: begin
				src = raw;
			end
			MODE_GRAY: begin
				src = {raw[15:8], raw[7:0], raw[7:0], raw[7:0]};
			end
			default: begin
				// Indexed, and the undefined mode which behaves the same.
				if (raw[7:0] == cur_transp_idx)
					src = '0;
				else
					src = palette_shadow[raw[7:0]];
			end
		endcase
		sa = scale8(int'(src[31:24]), int'(cur_opacity));
		da = int'(dst[31:24]);
		a  = (sa + da - scale8(sa, da)) & 255;
		// Nothing left of either pixel: clear black.
		if (a == 0)
			return '0;
		res[31:24] = a[7:0];
		for (int c = 0; c < 3; c++)
			res[8*c +: 8] = mix_channel(int'(src[8*c +: 8]), int'(dst[8*c +: 8]), sa, a);
		return res;
	endfunction

	// Random idle length: mostly none, some short, a few long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Driver. It holds an item until the block takes it; the accepted item is
	// handed to the predictor at the very edge where the handshake happens.
	int        send_gap = 0;
	pix_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= CMD_PAL_WRITE;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_PAL_WRITE)
					palette_shadow[s_tdata[7:0]] = s_tdata[39:8];
				else
					expected_pixels.push_back(composite_pixel(s_tdata[71:40],
							s_tdata[103:72]));
			end
			// A stalled item stays on the bus untouched.
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap != 0 || pending_items.size() == 0) begin
					s_tvalid <= 1'b0;
					if (send_gap != 0)
						send_gap--;
				end else begin
					next_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {next_item.dst, next_item.src, next_item.color,
							next_item.addr};
					s_tuser  <= next_item.cmd;
					send_gap = calm ? 0 : idle_len();
				end
			end
		end
	end

	// Monitor. Checks each accepted pixel against the oldest prediction and
	// throttles m_tready, including two long hold-offs that fill the pipeline
	// and force the block to stall its input. A hold-off waits until enough
	// items are queued for the sender to keep offering through it.
	int          recv_wait = 0;
	int          hold_left = 0;
	int          holds_done = 0;
	logic [31:0] want_pixel;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_pixels.size() == 0) begin
					n_errors++;
					$display("%0t: out_color expected none, actual %08h", $time, m_tdata);
				end else begin
					want_pixel = expected_pixels.pop_front();
					if (m_tdata !== want_pixel) begin
						n_errors++;
						$display("%0t: out_color expected %08h, actual %08h", $time,
								want_pixel, m_tdata);
					end
				end
				if (((holds_done == 0 && n_results >= 150)
						|| (holds_done == 1 && n_results >= 450))
						&& pending_items.size() > 20) begin
					hold_left = 150;
					holds_done++;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_wait != 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 12) begin
				recv_wait = idle_len();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [31:0] color);
		pix_item_t it;
		it.cmd   = CMD_PAL_WRITE;
		it.addr  = addr;
		it.color = color;
		it.src   = $urandom;
		it.dst   = $urandom;
		pending_items.push_back(it);
		if (!gen_written[addr]) begin
			gen_written[addr] = 1'b1;
			gen_written_list.push_back(int'(addr));
		end
	endtask

	task automatic push_blend(input logic [31:0] src, input logic [31:0] dst);
		pix_item_t it;
		it.cmd   = CMD_BLEND;
		it.addr  = ADDR_W'($urandom);
		it.color = $urandom;
		it.src   = src;
		it.dst   = dst;
		pending_items.push_back(it);
	endtask

	// One random item for the current setting. Indexed phases write the palette
	// more often and only read entries that are written or transparent.
	task automatic push_random();
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  idx;
		bit          indexed;
		int          r;
		indexed = (cur_mode == MODE_INDEXED || cur_mode == MODE_ALIAS_IDX);
		r = $urandom_range(0, 99);
		if (r < (indexed ? 25 : 8)) begin
			push_write(ADDR_W'($urandom), $urandom);
		end else begin
			src = $urandom;
			dst = $urandom;
			// Weight the alpha bytes toward their extremes now and then.
			r = $urandom_range(0, 9);
			if (r == 0)
				dst[31:24] = 8'h00;
			else if (r == 1)
				dst[31:24] = 8'hFF;
			r = $urandom_range(0, 9);
			if (r == 0) begin
				src[31:24] = 8'h00;
				src[15:8]  = 8'h00;
			end else if (r == 1) begin
				src[31:24] = 8'hFF;
				src[15:8]  = 8'hFF;
			end
			if (indexed) begin
				if ($urandom_range(0, 99) < 15)
					idx = cur_transp_idx;
				else
					idx = 8'(gen_written_list[$urandom_range(0,
							gen_written_list.size() - 1)]);
				src[7:0] = idx;
			end
			push_blend(src, dst);
		end
	endtask

	// Wait until the block is empty, then let any palette write drain.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges, keeping cfg_we high.
	task automatic apply_settings(input logic [MODE_W-1:0] mode,
			input logic [CHAN_W-1:0] opacity, input logic [CHAN_W-1:0] transp);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PIXEL_MODE;
		cfg_wdata <= CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_index <= CFG_OPACITY;
		cfg_wdata <= opacity;
		@(posedge clk);
		cfg_index <= CFG_TRANSP_IDX;
		cfg_wdata <= transp;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_mode       = mode;
		cur_opacity    = opacity;
		cur_transp_idx = transp;
	endtask

	// Stimulus: a directed pass over the special cases, then random settings.
	initial begin
		logic [MODE_W-1:0] mode;
		logic [CHAN_W-1:0] opacity;
		logic [CHAN_W-1:0] transp;
		wait (arst_n);
		@(posedge clk);

		// Reset settings: rgba at full opacity. Zero combined alpha, the opaque
		// and empty extremes, and a source darker than the destination.
		push_blend(32'h0000_0000, 32'h0000_0000);
		push_blend(32'hFFFF_FFFF, 32'h0000_0000);
		push_blend(32'h0000_0000, 32'hFFFF_FFFF);
		push_blend(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_blend(32'h80FF_0010, 32'h4000_FFF0);
		push_blend(32'h0100_00FF, 32'h01FF_FF00);
		// Palette writes at both ends of the address range, one fully clear.
		push_write(8'h00, 32'hFFFF_FFFF);
		push_write(8'hFF, 32'h8040_2010);
		push_write(8'h5A, 32'h0012_3456);
		push_write(8'hA5, 32'h7FFF_0080);
		drain();

		// Grayscale: the upper half of the raw word must be ignored.
		apply_settings(MODE_GRAY, 8'hFF, 8'h00);
		push_blend(32'hDEAD_803C, 32'hFF10_2030);
		push_blend(32'h0000_00FF, 32'h0000_0000);
		drain();

		// Indexed: the transparent index wins even over a written entry.
		apply_settings(MODE_INDEXED, 8'hFF, 8'h00);
		push_blend(32'h0000_0000, 32'h80A0_B0C0);
		push_blend(32'h0000_00FF, 32'h0000_0000);
		push_blend(32'h1234_565A, 32'hFF01_0203);
		push_blend(32'hFFFF_FFA5, 32'h7F7F_7F7F);
		drain();

		// The undefined mode decodes as indexed.
		apply_settings(MODE_ALIAS_IDX, 8'hC0, 8'hFF);
		push_blend(32'h0000_00FF, 32'hFF33_2211);
		push_blend(32'hFFFF_FF00, 32'h8011_2233);
		drain();

		// Zero and minimal opacity in rgba mode.
		apply_settings(MODE_RGBA, 8'h00, 8'h00);
		push_blend(32'hFFFF_FFFF, 32'h0000_0000);
		push_blend(32'hFFFF_FFFF, 32'h8011_2233);
		drain();
		apply_settings(MODE_RGBA, 8'h01, 8'h00);
		push_blend(32'hFF80_4020, 32'h00FF_FFFF);
		drain();

		// Random part, one register setting per phase. Two phases run with no random
		// idle cycles on either side; every phase boundary is a full pause.
		for (int ph = 0; ph < SETTING_COUNT; ph++) begin
			mode = MODE_W'(ph % 4);
			case (ph % 5)
				0: opacity = 8'hFF;
				1: opacity = 8'h00;
				2: opacity = 8'h01;
				default: opacity = 8'($urandom_range(0, 255));
			endcase
			case (ph % 3)
				0: transp = 8'h00;
				1: transp = 8'hFF;
				default: transp = 8'($urandom_range(0, 255));
			endcase
			apply_settings(mode, opacity, transp);
			calm = (ph == 4 || ph == 9);
			repeat (ITEMS_PER_SETTING) push_random();
			drain();
		end
		calm = 1'b0;

		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
